### src/frla_pkg.sv
package frla_pkg;

    // Field widths fixed by the interface.
    localparam int OPCODE_W   = 2;
    localparam int OFFSET_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = 25;
    localparam int COUNT_W    = 16;
    localparam int PAGE_W     = 12;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Record numbers after a wrap-around sum need one bit more than a count.
    localparam int RECNO_W    = COUNT_W + 1;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOCATE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 2'd2;

    // Register values after reset.
    localparam logic [PAGE_W-1:0] RST_START_PAGE    = 12'd0;
    localparam logic [PAGE_W-1:0] RST_PAGE_COUNT    = 12'd0;
    localparam logic [LEN_W-1:0]  RST_RECORD_LENGTH = 13'd16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [OFFSET_W-1:0] back_offset;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   flash_address;
        logic [COUNT_W-1:0]  record_count;
    } t_out;

endpackage

### src/frla_div.sv
module frla_div #(
    parameter int W = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;

    logic [W:0]    rem_sh;
    logic [W:0]    trial;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        rem_sh = {r_rem, r_quot[W-1]};
        trial  = rem_sh - {1'b0, r_dvs};
    end

    // Control and the shifting quotient/remainder pair, one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[W-2:0], ~trial[W]};
            r_rem  <= trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### src/flash_ring_log_addresser_core.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+------------------------------
// in        | i_in_valid / o_in_ready      | i_in_data  (frla_pkg::t_in)
// out       | o_out_valid / i_out_ready    | o_out_data (frla_pkg::t_out)
// config    | i_cfg_we (no wait)           | i_cfg_index, i_cfg_wdata
//
// A query, a locate that finds nothing or any operation without space goes from the
// evaluate state to the done state; an append or a found locate passes the divide and
// the two address states, the shared bit-serial divider giving page and slot. The first
// item after a reset or a register write goes through setup, where the same divider
// derives the records per page unless the record length leaves no space.
// Reset is synchronous, active low; a result held by an output stall blocks the sequencer.
module flash_ring_log_addresser_core #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  frla_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output frla_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [frla_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [frla_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int PB_W  = $clog2(PAGE_BYTES + 1);
    localparam int DW    = (PB_W > frla_pkg::RECNO_W) ? PB_W : frla_pkg::RECNO_W;
    localparam int MA_W  = DW + 1;
    localparam int MB_W  = (PB_W > frla_pkg::LEN_W) ? PB_W : frla_pkg::LEN_W;
    localparam int MP_W  = MA_W + MB_W;
    localparam int AW    = frla_pkg::ADDR_W;
    localparam int CNT_W = frla_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_PPDIV,
        S_TOTAL,
        S_USABLE,
        S_EVAL,
        S_RDIV,
        S_ADDR_HI,
        S_ADDR_LO,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration and derived geometry.
    logic [frla_pkg::PAGE_W-1:0] r_start_page;
    logic [frla_pkg::PAGE_W-1:0] r_page_count;
    logic [frla_pkg::LEN_W-1:0]  r_len;
    logic                        r_dirty;
    logic [PB_W-1:0]             r_per_page;
    logic [CNT_W-1:0]            r_total;
    logic [CNT_W-1:0]            r_usable;

    // Log state.
    logic [CNT_W-1:0]            r_cur;
    logic [CNT_W-1:0]            r_stored;

    // Item in work and its result.
    logic [frla_pkg::OPCODE_W-1:0] r_op;
    logic [frla_pkg::OFFSET_W-1:0] r_back;
    logic [frla_pkg::STATUS_W-1:0] r_status;
    logic [AW-1:0]                 r_addr;
    logic [CNT_W-1:0]              r_count;

    logic                          r_out_valid;
    frla_pkg::t_out                r_out_data;

    logic                          len_ok;
    logic                          no_space;
    logic                          out_free;
    logic [CNT_W-1:0]              avail;
    logic [frla_pkg::RECNO_W-1:0]  app_inc;
    logic [frla_pkg::RECNO_W-1:0]  app_recno;
    logic [frla_pkg::RECNO_W-1:0]  loc_recno;
    logic                          need_rdiv;
    logic                          div_start;
    logic [DW-1:0]                 div_dividend;
    logic [DW-1:0]                 div_divisor;
    logic                          div_done;
    logic [DW-1:0]                 div_quot;
    logic [DW-1:0]                 div_rem;
    logic [MA_W-1:0]               mul_a;
    logic [MB_W-1:0]               mul_b;
    logic [MP_W-1:0]               mul_p;
    logic [CNT_W-1:0]              n_clamped;

    // Geometry checks and the stored count as the log sees it.
    always_comb begin
        len_ok   = (r_len != '0) && (32'(r_len) <= 32'(PAGE_BYTES));
        no_space = (r_page_count == '0) || (r_per_page == '0);
        out_free = !r_out_valid || i_out_ready;
        avail    = (r_stored > r_usable) ? '0 : r_stored;
    end

    // Next record for an append, and the record a locate points at.
    always_comb begin
        app_inc = {1'b0, r_cur} + frla_pkg::RECNO_W'(1);
        if ((app_inc >= {1'b0, r_total}) || (avail == '0)) begin
            app_recno = '0;
        end else begin
            app_recno = app_inc;
        end
        if (r_cur >= r_back) begin
            loc_recno = {1'b0, r_cur} - {1'b0, r_back};
        end else begin
            loc_recno = {1'b0, r_cur} + {1'b0, r_total} - {1'b0, r_back};
        end
        need_rdiv = (r_op == frla_pkg::OP_APPEND) ||
                    ((r_op == frla_pkg::OP_LOCATE) && (r_back < avail));
    end

    // Divider requests: records per page at setup, page and slot for an append or a found locate.
    always_comb begin
        div_start    = ((r_state == S_SETUP) && len_ok) ||
                       ((r_state == S_EVAL) && !no_space && need_rdiv);
        div_dividend = '0;
        div_divisor  = '0;
        if (r_state == S_SETUP) begin
            div_dividend = DW'(PAGE_BYTES);
            div_divisor  = DW'(r_len);
        end else begin
            div_dividend = (r_op == frla_pkg::OP_APPEND) ? DW'(app_recno) : DW'(loc_recno);
            div_divisor  = DW'(r_per_page);
        end
    end

    frla_div #(
        .W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // One multiplier shared by the totals and the two address terms.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_TOTAL: begin
                mul_a = MA_W'(r_page_count);
                mul_b = MB_W'(r_per_page);
            end
            S_USABLE: begin
                mul_a = MA_W'(r_page_count - frla_pkg::PAGE_W'(1));
                mul_b = MB_W'(r_per_page);
            end
            S_ADDR_HI: begin
                mul_a = MA_W'(r_start_page) + MA_W'(div_quot);
                mul_b = MB_W'(PAGE_BYTES);
            end
            S_ADDR_LO: begin
                mul_a = MA_W'(div_rem);
                mul_b = MB_W'(r_len);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p     = MP_W'(mul_a) * MP_W'(mul_b);
        n_clamped = (mul_p[MP_W-1:CNT_W] != '0) ? frla_pkg::COUNT_MAX : mul_p[CNT_W-1:0];
    end

    // Sequencer, configuration registers, log state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_page <= frla_pkg::RST_START_PAGE;
            r_page_count <= frla_pkg::RST_PAGE_COUNT;
            r_len        <= frla_pkg::RST_RECORD_LENGTH;
            r_dirty      <= 1'b1;
            r_per_page   <= '0;
            r_total      <= '0;
            r_usable     <= '0;
            r_cur        <= '0;
            r_stored     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                case (i_cfg_index)
                    frla_pkg::CFG_START_PAGE:    r_start_page <= i_cfg_wdata[frla_pkg::PAGE_W-1:0];
                    frla_pkg::CFG_PAGE_COUNT:    r_page_count <= i_cfg_wdata[frla_pkg::PAGE_W-1:0];
                    frla_pkg::CFG_RECORD_LENGTH: r_len        <= i_cfg_wdata[frla_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end

            // The done state reloads the output register itself.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.opcode;
                        r_back  <= i_in_data.back_offset;
                        r_state <= r_dirty ? S_SETUP : S_EVAL;
                    end
                end
                S_SETUP: begin
                    if (len_ok) begin
                        r_state <= S_PPDIV;
                    end else begin
                        r_per_page <= '0;
                        if (!i_cfg_we) begin
                            r_dirty <= 1'b0;
                        end
                        r_state    <= S_EVAL;
                    end
                end
                S_PPDIV: begin
                    if (div_done) begin
                        r_per_page <= div_quot[PB_W-1:0];
                        r_state    <= S_TOTAL;
                    end
                end
                S_TOTAL: begin
                    r_total <= n_clamped;
                    r_state <= S_USABLE;
                end
                S_USABLE: begin
                    r_usable <= n_clamped;
                    if (!i_cfg_we) begin
                        r_dirty <= 1'b0;
                    end
                    r_state  <= S_EVAL;
                end
                S_EVAL: begin
                    r_addr <= '0;
                    if (no_space) begin
                        r_status <= frla_pkg::ST_NO_SPACE;
                        r_count  <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        case (r_op)
                            frla_pkg::OP_APPEND: begin
                                r_status <= frla_pkg::ST_OK;
                                r_cur    <= app_recno[CNT_W-1:0];
                                if (avail < r_usable) begin
                                    r_stored <= avail + CNT_W'(1);
                                    r_count  <= avail + CNT_W'(1);
                                end else begin
                                    r_count  <= avail;
                                end
                                r_state <= S_RDIV;
                            end
                            frla_pkg::OP_LOCATE: begin
                                r_count <= avail;
                                if (r_back >= avail) begin
                                    r_status <= frla_pkg::ST_NOT_FOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= frla_pkg::ST_OK;
                                    r_state  <= S_RDIV;
                                end
                            end
                            default: begin
                                r_status <= frla_pkg::ST_OK;
                                r_count  <= avail;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RDIV: begin
                    if (div_done) begin
                        r_state <= S_ADDR_HI;
                    end
                end
                S_ADDR_HI: begin
                    r_addr  <= mul_p[AW-1:0];
                    r_state <= S_ADDR_LO;
                end
                S_ADDR_LO: begin
                    r_addr  <= r_addr + mul_p[AW-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_data.status          <= r_status;
                        r_out_data.flash_address   <= r_addr;
                        r_out_data.record_count    <= r_count;
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // After a transfer in, the block is busy with that item and not ready in the cycle after.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a transfer");

    // Only a successful append or locate carries an address.
    a_addr_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != frla_pkg::ST_OK))
            |-> (o_out_data.flash_address == '0))
        else $error("address present with an error status");

    // Without space the log reports no records.
    a_no_space_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == frla_pkg::ST_NO_SPACE))
            |-> (o_out_data.record_count == '0))
        else $error("record count reported without space");

    // A result is published only when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("pending result overwritten");
`endif

endmodule
